### hdl/scbr_pkg.sv
// shared constants and codes for the size class block recycler
// no dependencies
package scbr_pkg;

  localparam int NUM_BUCKETS  = 32;
  localparam int BUCKET_DEPTH = 16;
  localparam int SINK_DEPTH   = 16;
  localparam int PAGE_SHIFT   = 12;
  localparam int HANDLE_BITS  = 16;

  localparam int BYTES_W  = 48;
  localparam int SIZE_W   = 49;
  localparam int CLASS_W  = 37;
  localparam int MINP_W   = 8;
  localparam int HANDLE_W = 16;
  localparam int STATUS_W = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 37;

  localparam int BKT_W      = $clog2(NUM_BUCKETS);
  localparam int SLOT_W     = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
  localparam int FILL_W     = $clog2(BUCKET_DEPTH + 1);
  localparam int SINK_IDX_W = (SINK_DEPTH > 1) ? $clog2(SINK_DEPTH) : 1;
  localparam int SINK_CNT_W = $clog2(SINK_DEPTH + 1);
  localparam int MEM_DEPTH  = NUM_BUCKETS * BUCKET_DEPTH;
  localparam int MEM_AW     = $clog2(MEM_DEPTH);
  localparam int PAGES_W    = SIZE_W - PAGE_SHIFT;

  typedef enum logic [STATUS_W-1:0] {
    ST_BUCKET  = 3'd0,
    ST_SINK    = 3'd1,
    ST_FRESH   = 3'd2,
    ST_KEPT    = 3'd3,
    ST_RELEASE = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_PAGES = 2'd0,
    REG_RETAIN_LIMIT = 2'd1,
    REG_RETAIN_UNLIMITED = 2'd2
  } cfg_reg_t;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

endpackage

### hdl/scbr_ram.sv
// single port write, single port read ram with registered read data
// generic, no package dependency
module scbr_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hdl/size_class_block_recycler_top.sv
// size class block recycler: sequencer, fill counters, sink store, result regs
// depends on scbr_pkg and scbr_ram
//
// Usage: a request is taken when start is high and busy is low. command 0
// allocates request_bytes (rounded up to pages, raised to min_pages), command
// 1 frees block_handle of class block_class. Exactly one result follows per
// request, shown on status, out_handle, out_class and fresh_bytes for one
// cycle while done is high; the receiver cannot stall it.
// Sequence: a free passes through S_PREP, S_FDEC and S_FIN before done. An
// allocate passes through S_PREP, S_INDEX and S_ROUTE, then scans the buckets
// from its index upward, reads the handle in S_BREAD and, when the top bucket
// empties, steps down through S_DROP; a sink allocate instead scans the sink
// entries oldest first until one fits or none is left; S_FIN raises done.
// Only one request is in flight at a time; the scans over the fill counters
// and the sink set how long busy stays high.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 min_pages,
// 1 retain limit, which also reloads the page budget, 2 retain unlimited);
// write only while busy is low.
// Reset: rst clears all buckets and the sink at once; no clearing pass.
module size_class_block_recycler_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              command,
  input  logic [scbr_pkg::BYTES_W-1:0]      request_bytes,
  input  logic [scbr_pkg::HANDLE_W-1:0]     block_handle,
  input  logic [scbr_pkg::CLASS_W-1:0]      block_class,
  output logic                              done,
  output logic [scbr_pkg::STATUS_W-1:0]     status,
  output logic [scbr_pkg::HANDLE_W-1:0]     out_handle,
  output logic [scbr_pkg::CLASS_W-1:0]      out_class,
  output logic [scbr_pkg::SIZE_W-1:0]       fresh_bytes,
  input  logic                              cfg_we,
  input  logic [scbr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [scbr_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import scbr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_INDEX, S_ROUTE, S_BSCAN, S_BREAD, S_DROP,
    S_SSCAN, S_FDEC, S_FIN
  } state_t;

  localparam logic [SIZE_W-1:0] PAGE_MASK = SIZE_W'((64'd1 << PAGE_SHIFT) - 64'd1);

  state_t state;

  // configuration
  logic [MINP_W-1:0]  min_pages;
  logic [CLASS_W-1:0] retain_limit;
  logic               retain_unlimited;
  logic [CLASS_W-1:0] free_budget;

  // latched request
  logic                cmd_q;
  logic [BYTES_W-1:0]  bytes_q;
  logic [HANDLE_W-1:0] handle_q;
  logic [CLASS_W-1:0]  class_q;

  // working registers
  logic [PAGES_W-1:0]  pages_q;
  logic [SIZE_W-1:0]   size_q;
  logic [CLASS_W-1:0]  idx_q;
  logic [CLASS_W:0]    cost_q;
  logic [BKT_W-1:0]    scan_i;
  logic [BKT_W-1:0]    drop_j;
  logic [SINK_CNT_W-1:0] scan_k;

  // bucket bookkeeping
  logic [FILL_W-1:0]   bucket_fill [NUM_BUCKETS];
  logic [BKT_W-1:0]    highest_bucket;

  // sink store
  logic [HANDLE_W-1:0] sink_handle [SINK_DEPTH];
  logic [CLASS_W-1:0]  sink_class  [SINK_DEPTH];
  logic [SINK_CNT_W-1:0] sink_fill;

  // handle memory signals
  logic              ram_we;
  logic [MEM_AW-1:0] ram_waddr;
  logic [MEM_AW-1:0] ram_raddr;
  logic [HANDLE_W-1:0] ram_rdata;

  logic [SIZE_W-1:0]  rounded;
  logic [PAGES_W-1:0] rounded_pages;
  logic [FILL_W-1:0]  fill_i;
  logic [FILL_W-1:0]  fill_i_dec;
  logic [BKT_W-1:0]   free_bkt;
  logic [FILL_W-1:0]  fill_free;
  logic [CLASS_W+1:0] add_bucket;
  logic [CLASS_W+1:0] add_sink;
  logic [SINK_IDX_W-1:0] k_idx;
  logic [SINK_IDX_W-1:0] push_idx;
  logic               take_sink;

  assign busy = (state != S_IDLE);

  // size rounding and address forming
  always_comb begin
    rounded       = ({1'b0, bytes_q} + PAGE_MASK) & ~PAGE_MASK;
    rounded_pages = rounded[SIZE_W-1:PAGE_SHIFT];
    fill_i        = bucket_fill[scan_i];
    fill_i_dec    = fill_i - FILL_W'(1);
    free_bkt      = class_q[BKT_W-1:0];
    fill_free     = bucket_fill[free_bkt];
    ram_raddr     = {scan_i, fill_i_dec[SLOT_W-1:0]};
    ram_waddr     = {free_bkt, fill_free[SLOT_W-1:0]};
    ram_we        = (state == S_FDEC) && (class_q != '0)
                    && (retain_unlimited || cost_q <= {1'b0, free_budget})
                    && (class_q < CLASS_W'(NUM_BUCKETS))
                    && (fill_free < FILL_W'(BUCKET_DEPTH));
    add_bucket    = {2'b0, free_budget} + {{(CLASS_W+2-BKT_W){1'b0}}, scan_i}
                    + {{(CLASS_W+2-MINP_W){1'b0}}, min_pages} - (CLASS_W+2)'(1);
    k_idx         = scan_k[SINK_IDX_W-1:0];
    push_idx      = sink_fill[SINK_IDX_W-1:0];
    add_sink      = {2'b0, free_budget} + {2'b0, sink_class[k_idx]}
                    + {{(CLASS_W+2-MINP_W){1'b0}}, min_pages} - (CLASS_W+2)'(1);
    take_sink     = (scan_k < sink_fill) && (sink_class[k_idx] >= idx_q);
  end

  scbr_ram #(.DEPTH(MEM_DEPTH), .WIDTH(HANDLE_W)) u_handles (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (handle_q),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer, stores and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      done             <= 1'b0;
      min_pages        <= MINP_W'(1);
      retain_limit     <= '0;
      retain_unlimited <= 1'b1;
      free_budget      <= '0;
      highest_bucket   <= '0;
      sink_fill        <= '0;
      for (int b = 0; b < NUM_BUCKETS; b++) begin
        bucket_fill[b] <= '0;
      end
    end else begin
      done <= 1'b0;

      // configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MIN_PAGES: min_pages <= cfg_data[MINP_W-1:0];
          REG_RETAIN_LIMIT: begin
            retain_limit <= cfg_data;
            free_budget  <= cfg_data;
          end
          REG_RETAIN_UNLIMITED: retain_unlimited <= cfg_data[0];
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd_q    <= command;
            bytes_q  <= request_bytes;
            handle_q <= block_handle;
            class_q  <= block_class;
            state    <= S_PREP;
          end
        end

        S_PREP: begin
          if (cmd_q == CMD_ALLOC) begin
            // raise to the minimum block size
            if (rounded_pages < PAGES_W'(min_pages)) begin
              pages_q <= PAGES_W'(min_pages);
              size_q  <= SIZE_W'(min_pages) << PAGE_SHIFT;
            end else begin
              pages_q <= rounded_pages;
              size_q  <= rounded;
            end
            state <= S_INDEX;
          end else begin
            cost_q <= {1'b0, class_q} + (CLASS_W+1)'(min_pages) - (CLASS_W+1)'(1);
            state  <= S_FDEC;
          end
        end

        S_INDEX: begin
          idx_q <= CLASS_W'(pages_q - PAGES_W'(min_pages) + PAGES_W'(1));
          state <= S_ROUTE;
        end

        S_ROUTE: begin
          scan_i <= idx_q[BKT_W-1:0];
          scan_k <= '0;
          if (idx_q <= CLASS_W'(highest_bucket)) begin
            state <= S_BSCAN;
          end else begin
            state <= S_SSCAN;
          end
        end

        // walk buckets from the index up to the top one
        S_BSCAN: begin
          if (fill_i != '0) begin
            bucket_fill[scan_i] <= fill_i_dec;
            state <= S_BREAD;
          end else if (scan_i == highest_bucket) begin
            status      <= ST_FRESH;
            out_handle  <= '0;
            out_class   <= idx_q;
            fresh_bytes <= size_q;
            state       <= S_FIN;
          end else begin
            scan_i <= scan_i + BKT_W'(1);
          end
        end

        // handle read back, budget credit
        S_BREAD: begin
          status      <= ST_BUCKET;
          out_handle  <= ram_rdata;
          out_class   <= CLASS_W'(scan_i);
          fresh_bytes <= '0;
          free_budget <= (add_bucket > (CLASS_W+2)'(retain_limit))
                         ? retain_limit : add_bucket[CLASS_W-1:0];
          drop_j      <= scan_i;
          if (fill_i == '0 && scan_i == highest_bucket) begin
            state <= S_DROP;
          end else begin
            state <= S_FIN;
          end
        end

        // top bucket emptied: step down to the next occupied one, or to bucket 0
        S_DROP: begin
          if (drop_j != '0 && bucket_fill[drop_j] == '0) begin
            drop_j <= drop_j - BKT_W'(1);
          end else begin
            highest_bucket <= drop_j;
            state          <= S_FIN;
          end
        end

        // oldest first search of the sink
        S_SSCAN: begin
          if (take_sink) begin
            status      <= ST_SINK;
            out_handle  <= sink_handle[k_idx];
            out_class   <= sink_class[k_idx];
            fresh_bytes <= '0;
            free_budget <= (add_sink > (CLASS_W+2)'(retain_limit))
                           ? retain_limit : add_sink[CLASS_W-1:0];
            for (int p = 0; p < SINK_DEPTH - 1; p++) begin
              if (SINK_CNT_W'(p) >= scan_k) begin
                sink_handle[p] <= sink_handle[p+1];
                sink_class[p]  <= sink_class[p+1];
              end
            end
            sink_fill <= sink_fill - SINK_CNT_W'(1);
            state     <= S_FIN;
          end else if (scan_k >= sink_fill) begin
            status      <= ST_FRESH;
            out_handle  <= '0;
            out_class   <= idx_q;
            fresh_bytes <= size_q;
            state       <= S_FIN;
          end else begin
            scan_k <= scan_k + SINK_CNT_W'(1);
          end
        end

        // free: keep or release
        S_FDEC: begin
          out_class   <= '0;
          fresh_bytes <= '0;
          state       <= S_FIN;
          if (class_q == '0
              || (!retain_unlimited && cost_q > {1'b0, free_budget})) begin
            status     <= ST_RELEASE;
            out_handle <= handle_q;
          end else if (class_q < CLASS_W'(NUM_BUCKETS)) begin
            if (fill_free >= FILL_W'(BUCKET_DEPTH)) begin
              status     <= ST_RELEASE;
              out_handle <= handle_q;
            end else begin
              bucket_fill[free_bkt] <= fill_free + FILL_W'(1);
              if (free_bkt > highest_bucket) begin
                highest_bucket <= free_bkt;
              end
              free_budget <= (cost_q <= {1'b0, free_budget})
                             ? free_budget - cost_q[CLASS_W-1:0] : '0;
              status     <= ST_KEPT;
              out_handle <= '0;
            end
          end else begin
            if (sink_fill >= SINK_CNT_W'(SINK_DEPTH)) begin
              status     <= ST_RELEASE;
              out_handle <= handle_q;
            end else begin
              sink_handle[push_idx] <= handle_q;
              sink_class[push_idx]  <= class_q;
              sink_fill   <= sink_fill + SINK_CNT_W'(1);
              free_budget <= (cost_q <= {1'b0, free_budget})
                             ? free_budget - cost_q[CLASS_W-1:0] : '0;
              status     <= ST_KEPT;
              out_handle <= '0;
            end
          end
        end

        S_FIN: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
